[rtl/assert_macros.svh]
// Assertion helpers for the rate meter; clocked on clk, quiet during rst
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define FIRM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define FIRM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/firm_pkg.sv]
`default_nettype none
package firm_pkg;

  // field widths
  localparam int TIME_W   = 48;
  localparam int WEIGHT_W = 16;
  localparam int COUNT_W  = 16;
  localparam int FRAME_W  = 32;
  localparam int RATE_W   = 48;
  localparam int PHASE_W  = 16;
  localparam int REG_IDX_W = 2;

  // rate numerator: TICK_HZ in Q.RATE_FRAC
  localparam longint unsigned TICK_HZ   = 64'd1000000;
  localparam int              RATE_FRAC = 16;
  localparam logic [63:0] RATE_NUM_WIDE = 64'(TICK_HZ) << RATE_FRAC;
  localparam logic [TIME_W-1:0] RATE_NUM = RATE_NUM_WIDE[TIME_W-1:0];

  // product of difference and weight, and its fractional shift
  localparam int PROD_W = RATE_W + WEIGHT_W;

  // shared divider
  localparam int DIV_W     = 48;
  localparam int DIV_CNT_W = $clog2(DIV_W);

  typedef logic [TIME_W-1:0] tick_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_WEIGHT       = 2'd0,
    REG_PHASE_COUNT  = 2'd1,
    REG_PHASE_PERIOD = 2'd2,
    REG_PULSE_PERIOD = 2'd3
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RATE,
    S_DIFF,
    S_MUL,
    S_ADJ,
    S_PHASE_DIV,
    S_PHASE_MOD,
    S_PULSE_DIV,
    S_DONE
  } state_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quotient;
    logic [DIV_W-1:0] remainder;
  } div_rsp_t;

endpackage
`default_nettype wire

[rtl/firm_ifs.sv]
`default_nettype none
// stamp channel: one beat per frame stamp or restart
interface firm_stamp_if;
  logic                    valid;
  logic                    ready;
  logic                    func;
  logic [firm_pkg::TIME_W-1:0] timestamp;

  modport source (output valid, func, timestamp, input ready);
  modport sink   (input valid, func, timestamp, output ready);
endinterface

// result channel: one beat per counted frame
interface firm_result_if;
  logic                         valid;
  logic                         ready;
  logic [firm_pkg::TIME_W-1:0]  delta_ticks;
  logic [firm_pkg::TIME_W-1:0]  elapsed_ticks;
  logic [firm_pkg::FRAME_W-1:0] frame_number;
  logic [firm_pkg::RATE_W-1:0]  rate_average;
  logic [firm_pkg::PHASE_W-1:0] phase_index;
  logic                         pulse_level;

  modport source (output valid, delta_ticks, elapsed_ticks, frame_number, rate_average,
                  phase_index, pulse_level, input ready);
  modport sink   (input valid, delta_ticks, elapsed_ticks, frame_number, rate_average,
                  phase_index, pulse_level, output ready);
endinterface
`default_nettype wire

[rtl/firm_div.sv]
`default_nettype none
// Restoring divider, one quotient bit per cycle
module firm_div (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire firm_pkg::div_req_t req,
  output firm_pkg::div_rsp_t      rsp
);
  import firm_pkg::*;

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] count;
  logic [DIV_W-1:0]     quo;
  logic [DIV_W-1:0]     rem;
  logic [DIV_W-1:0]     divisor;

  logic [DIV_W:0]       partial;
  logic [DIV_W:0]       diff;
  logic                 fits;

  // trial subtract of the shifted remainder
  assign partial = {rem, quo[DIV_W-1]};
  assign diff    = partial - {1'b0, divisor};
  assign fits    = partial >= {1'b0, divisor};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 1'b1;
        if (count == DIV_CNT_W'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start && !busy) begin
      quo     <= req.dividend;
      rem     <= '0;
      divisor <= req.divisor;
    end else if (busy) begin
      quo <= {quo[DIV_W-2:0], fits};
      rem <= fits ? diff[DIV_W-1:0] : partial[DIV_W-1:0];
    end
  end

  assign rsp.busy      = busy;
  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule
`default_nettype wire

[rtl/frame_interval_rate_meter.sv]
`default_nettype none
// Channel   Dir  Beat carries
// stamp     in   func (0 stamp, 1 restart), timestamp[47:0]
// result    out  delta, elapsed, frame number, rate average, phase index, pulse level
// wr_*      in   register write: index, data[47:0], no read-back
//
// A restart or the first stamp after one is taken while idle and gives no beat.
// A counted stamp runs up to four passes of the shared divider (rate, phase
// quotient, phase modulo, pulse) plus the smoothing steps; fewer when the
// interval, the phase count or a period is zero.
// stamp.ready is high only while the sequencer is idle; the result sits in an
// output register, so a stalled result only holds up the next stamp at its end.
// Synchronous reset clears control state and the meter's running state.
module frame_interval_rate_meter (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               wr_en,
  input  wire logic [firm_pkg::REG_IDX_W-1:0]     wr_index,
  input  wire logic [firm_pkg::TIME_W-1:0]        wr_data,
  firm_stamp_if.sink                              stamp,
  firm_result_if.source                           result
);
  import firm_pkg::*;
  `include "assert_macros.svh"

  // configuration
  logic [WEIGHT_W-1:0] smoothing_weight;
  logic [COUNT_W-1:0]  phase_count;
  tick_t               phase_period;
  tick_t               pulse_period;

  // meter state
  logic                running;
  tick_t               origin_time;
  tick_t               last_time;
  logic [FRAME_W-1:0]  frame_total;
  logic [RATE_W-1:0]   rate_smoothed;

  // working registers
  state_t              state, state_next;
  logic                issued, issued_next;
  tick_t               delta;
  tick_t               elapsed;
  logic [RATE_W-1:0]   rate_inst;
  logic [RATE_W-1:0]   diff;
  logic                up;
  logic [RATE_W-1:0]   step;
  logic [DIV_W-1:0]    phase_quot;
  logic [PHASE_W-1:0]  phase;
  logic                pulse;
  logic                out_valid;
  logic                load_out;

  div_req_t            div_req;
  div_rsp_t            div_rsp;

  logic                phase_on, pulse_on;
  state_t              after_rate, after_phase;
  logic                stamp_take;
  logic [PROD_W-1:0]   prod;

  firm_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      smoothing_weight <= WEIGHT_W'(6554);
      phase_count      <= '0;
      phase_period     <= '0;
      pulse_period     <= '0;
    end else if (wr_en) begin
      unique case (cfg_reg_t'(wr_index))
        REG_WEIGHT:       smoothing_weight <= wr_data[WEIGHT_W-1:0];
        REG_PHASE_COUNT:  phase_count      <= wr_data[COUNT_W-1:0];
        REG_PHASE_PERIOD: phase_period     <= wr_data;
        REG_PULSE_PERIOD: pulse_period     <= wr_data;
        default: ;
      endcase
    end
  end

  // which optional passes run
  assign phase_on    = (phase_count != '0) && (phase_period != '0);
  assign pulse_on    = (pulse_period != '0);
  assign after_phase = pulse_on ? S_PULSE_DIV : S_DONE;
  assign after_rate  = phase_on ? S_PHASE_DIV : after_phase;

  assign stamp_take  = stamp.valid && stamp.ready;

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      issued <= 1'b0;
    end else begin
      state  <= state_next;
      issued <= issued_next;
    end
  end

  // next state and divider requests
  always_comb begin
    state_next  = state;
    issued_next = issued;
    div_req     = '0;
    stamp.ready = 1'b0;
    load_out    = 1'b0;
    unique case (state)
      S_IDLE: begin
        stamp.ready = 1'b1;
        if (stamp.valid && !stamp.func && running) begin
          state_next = S_RATE;
        end
      end
      S_RATE: begin
        div_req.dividend = RATE_NUM;
        div_req.divisor  = delta;
        if (delta == '0) begin
          state_next = after_rate;
        end else if (!issued) begin
          div_req.start = 1'b1;
          issued_next   = 1'b1;
        end else if (div_rsp.done) begin
          issued_next = 1'b0;
          state_next  = S_DIFF;
        end
      end
      S_DIFF: begin
        state_next = (rate_smoothed == '0) ? after_rate : S_MUL;
      end
      S_MUL: begin
        state_next = S_ADJ;
      end
      S_ADJ: begin
        state_next = after_rate;
      end
      S_PHASE_DIV: begin
        div_req.dividend = elapsed;
        div_req.divisor  = phase_period;
        if (!issued) begin
          div_req.start = 1'b1;
          issued_next   = 1'b1;
        end else if (div_rsp.done) begin
          issued_next = 1'b0;
          state_next  = S_PHASE_MOD;
        end
      end
      S_PHASE_MOD: begin
        div_req.dividend = phase_quot;
        div_req.divisor  = DIV_W'(phase_count);
        if (!issued) begin
          div_req.start = 1'b1;
          issued_next   = 1'b1;
        end else if (div_rsp.done) begin
          issued_next = 1'b0;
          state_next  = after_phase;
        end
      end
      S_PULSE_DIV: begin
        div_req.dividend = elapsed;
        div_req.divisor  = pulse_period;
        if (!issued) begin
          div_req.start = 1'b1;
          issued_next   = 1'b1;
        end else if (div_rsp.done) begin
          issued_next = 1'b0;
          state_next  = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid || result.ready) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next  = S_IDLE;
        issued_next = 1'b0;
      end
    endcase
  end

  // meter state: restart, origin capture, frame advance, smoothing
  always_ff @(posedge clk) begin
    if (rst) begin
      running       <= 1'b0;
      origin_time   <= '0;
      last_time     <= '0;
      frame_total   <= '0;
      rate_smoothed <= '0;
    end else begin
      if (stamp_take) begin
        if (stamp.func) begin
          running       <= 1'b0;
          frame_total   <= '0;
          rate_smoothed <= '0;
        end else if (!running) begin
          running     <= 1'b1;
          origin_time <= stamp.timestamp;
          last_time   <= stamp.timestamp;
        end else begin
          last_time   <= stamp.timestamp;
          frame_total <= frame_total + 1'b1;
        end
      end
      if (state == S_DIFF && rate_smoothed == '0) begin
        rate_smoothed <= rate_inst;
      end
      if (state == S_ADJ) begin
        rate_smoothed <= up ? rate_smoothed + step : rate_smoothed - step;
      end
    end
  end

  // weighted step, truncated toward the old average
  assign prod = PROD_W'(diff) * PROD_W'(smoothing_weight);

  // working datapath
  always_ff @(posedge clk) begin
    if (stamp_take && !stamp.func && running) begin
      delta   <= stamp.timestamp - last_time;
      elapsed <= stamp.timestamp - origin_time;
      phase   <= '0;
      pulse   <= 1'b0;
    end
    if (state == S_RATE && div_rsp.done) begin
      rate_inst <= div_rsp.quotient;
    end
    if (state == S_DIFF) begin
      up   <= rate_inst >= rate_smoothed;
      diff <= (rate_inst >= rate_smoothed) ? rate_inst - rate_smoothed
                                           : rate_smoothed - rate_inst;
    end
    if (state == S_MUL) begin
      step <= prod[PROD_W-1:WEIGHT_W];
    end
    if (state == S_PHASE_DIV && div_rsp.done) begin
      phase_quot <= div_rsp.quotient;
    end
    if (state == S_PHASE_MOD && div_rsp.done) begin
      phase <= div_rsp.remainder[PHASE_W-1:0];
    end
    if (state == S_PULSE_DIV && div_rsp.done) begin
      pulse <= ~div_rsp.quotient[0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      result.delta_ticks   <= delta;
      result.elapsed_ticks <= elapsed;
      result.frame_number  <= frame_total;
      result.rate_average  <= rate_smoothed;
      result.phase_index   <= phase;
      result.pulse_level   <= pulse;
    end
  end

  assign result.valid = out_valid;

  // checks
  `FIRM_ASSERT_NOW(a_idle_div_quiet, state == S_IDLE, !div_rsp.busy, "divider busy while idle")
  `FIRM_ASSERT_NOW(a_start_when_free, div_req.start, !div_rsp.busy, "divider restarted mid-run")
  `FIRM_ASSERT_NEXT(a_hold_when_full, state == S_DONE && out_valid && !result.ready,
    state == S_DONE, "result loaded over a waiting beat")

endmodule
`default_nettype wire

[tb/sv/testbench.sv]
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import firm_pkg::*;

  localparam logic FUNC_STAMP   = 1'b0;
  localparam logic FUNC_RESTART = 1'b1;

  localparam int ITEMS_PER_SETTING = 150;
  localparam int SETTING_COUNT     = 9;
  localparam int SETTLE_CYCLES     = 16;
  localparam int DRAIN_CYCLES      = 400;
  localparam int QUIET_LIMIT       = 5000;

  localparam tick_t       TICK_MAX   = '1;
  localparam logic [63:0] RATE_NUMER = 64'(TICK_HZ) << RATE_FRAC;
  localparam int unsigned FRAME_STEPS [0:3] = '{8333, 16667, 33333, 41667};

  typedef struct packed {
    logic  func;
    tick_t ts;
  } stamp_cmd_t;

  typedef struct packed {
    tick_t                delta;
    tick_t                elapsed;
    logic [FRAME_W-1:0]   frame;
    logic [RATE_W-1:0]    rate;
    logic [PHASE_W-1:0]   phase;
    logic                 pulse;
  } frame_report_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 wr_en;
  logic [REG_IDX_W-1:0] wr_index;
  tick_t                wr_data;

  firm_stamp_if  stamp_ch();
  firm_result_if report_ch();

  frame_interval_rate_meter i_dut (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .stamp    (stamp_ch),
    .result   (report_ch)
  );

  always #10ns clk = ~clk;

  // meter copy: registers and running state
  logic [WEIGHT_W-1:0] cfg_weight       = 16'd6554;
  logic [COUNT_W-1:0]  cfg_phase_count  = '0;
  tick_t               cfg_phase_period = '0;
  tick_t               cfg_pulse_period = '0;
  logic                meter_running    = 1'b0;
  tick_t               meter_origin     = '0;
  tick_t               meter_last       = '0;
  logic [FRAME_W-1:0]  meter_frames     = '0;
  logic [RATE_W-1:0]   meter_rate       = '0;

  stamp_cmd_t    pending_stamps[$];
  frame_report_t expected_reports[$];

  int  stamps_queued    = 0;
  int  stamps_accepted  = 0;
  int  stamp_total      = 0;
  int  restart_total    = 0;
  int  reports_checked  = 0;
  int  zero_intervals   = 0;
  int  wrapped_stamps   = 0;
  int  settings_applied = 0;
  int  failures         = 0;
  int  quiet_cycles     = 0;
  bit  stamp_taken;
  bit  report_taken;

  tick_t stim_clock = '0;
  bit    stim_fresh = 1'b1;

  int gap_left   = 0;
  int burst_left = 0;
  int ready_left = 0;

  function automatic tick_t rand48();
    return tick_t'({$urandom(), $urandom()});
  endfunction

  // works out the report a beat causes, if any, and advances the meter copy
  function automatic void predict_stamp(stamp_cmd_t cmd);
    frame_report_t rep;
    logic [63:0]   inst_rate;
    logic [63:0]   step;
    logic [63:0]   quot;
    if (cmd.func == FUNC_RESTART) begin
      meter_running = 1'b0;
      meter_frames  = '0;
      meter_rate    = '0;
      restart_total++;
      return;
    end
    stamp_total++;
    // first stamp after a restart only sets the origin
    if (!meter_running) begin
      meter_running = 1'b1;
      meter_origin  = cmd.ts;
      meter_last    = cmd.ts;
      return;
    end
    rep.delta   = cmd.ts - meter_last;
    rep.elapsed = cmd.ts - meter_origin;
    if (cmd.ts < meter_last) wrapped_stamps++;
    meter_last   = cmd.ts;
    meter_frames = meter_frames + 1'b1;
    // average held on a zero interval; step truncated towards the old value
    if (rep.delta == '0) begin
      zero_intervals++;
    end else begin
      inst_rate = RATE_NUMER / 64'(rep.delta);
      if (meter_rate == '0) begin
        meter_rate = inst_rate[RATE_W-1:0];
      end else if (inst_rate >= 64'(meter_rate)) begin
        step       = ((inst_rate - 64'(meter_rate)) * 64'(cfg_weight)) >> 16;
        meter_rate = meter_rate + step[RATE_W-1:0];
      end else begin
        step       = ((64'(meter_rate) - inst_rate) * 64'(cfg_weight)) >> 16;
        meter_rate = meter_rate - step[RATE_W-1:0];
      end
    end
    rep.frame = meter_frames;
    rep.rate  = meter_rate;
    rep.phase = '0;
    rep.pulse = 1'b0;
    if (cfg_phase_count != '0 && cfg_phase_period != '0) begin
      quot      = 64'(rep.elapsed) / 64'(cfg_phase_period);
      quot      = quot % 64'(cfg_phase_count);
      rep.phase = quot[PHASE_W-1:0];
    end
    if (cfg_pulse_period != '0) begin
      quot      = 64'(rep.elapsed) / 64'(cfg_pulse_period);
      rep.pulse = ~quot[0];
    end
    expected_reports.push_back(rep);
  endfunction

  function automatic void check_field(string field, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      failures++;
      $display("%0t: %s expected %0h got %0h", $time, field, want, got);
    end
  endfunction

  function automatic void push_stamp(logic func, tick_t ts);
    stamp_cmd_t cmd;
    cmd.func = func;
    cmd.ts   = ts;
    pending_stamps.push_back(cmd);
    stamps_queued++;
  endfunction

  // mostly frame-like intervals, with zero, one-tick, huge and wrapping ones and restarts mixed in
  function automatic stamp_cmd_t random_stamp();
    stamp_cmd_t cmd;
    tick_t      step;
    cmd.func = FUNC_STAMP;
    if ($urandom_range(0, 99) < 3) begin
      cmd.func   = FUNC_RESTART;
      cmd.ts     = rand48();
      stim_fresh = 1'b1;
      return cmd;
    end
    if (stim_fresh) begin
      case ($urandom_range(0, 3))
        0: stim_clock = rand48();
        1: stim_clock = TICK_MAX - tick_t'($urandom_range(0, 200000));
        default: stim_clock = stim_clock + tick_t'($urandom_range(0, 100000));
      endcase
      stim_fresh = 1'b0;
    end else begin
      case ($urandom_range(0, 19))
        0: step = '0;
        1: step = tick_t'(1);
        2: step = rand48();
        // around the point where the rate floors at zero
        3: step = tick_t'({$urandom_range(0, 63), $urandom()});
        4: step = tick_t'($urandom_range(1, 1 << 20));
        default: begin
          step = tick_t'(FRAME_STEPS[$urandom_range(0, 3)] + $urandom_range(0, 1000));
          step = step - tick_t'(500);
        end
      endcase
      stim_clock = stim_clock + step;
    end
    cmd.ts = stim_clock;
    return cmd;
  endfunction

  task automatic write_reg(cfg_reg_t idx, logic [63:0] val);
    @(negedge clk);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= val[TIME_W-1:0];
    @(negedge clk);
    wr_en    <= 1'b0;
    case (idx)
      REG_WEIGHT:       cfg_weight       = val[WEIGHT_W-1:0];
      REG_PHASE_COUNT:  cfg_phase_count  = val[COUNT_W-1:0];
      REG_PHASE_PERIOD: cfg_phase_period = val[TIME_W-1:0];
      REG_PULSE_PERIOD: cfg_pulse_period = val[TIME_W-1:0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (stamps_accepted != stamps_queued || expected_reports.size() != 0) @(negedge clk);
  endtask

  // register sets: fixed ones first, starting with the extremes, then random ones
  task automatic apply_setting(int k);
    logic [63:0] w, c, pp, pu;
    repeat (SETTLE_CYCLES) @(negedge clk);
    case (k)
      1: begin w = 65535; c = 65535; pp = 1; pu = 1; end
      2: begin w = 0; c = 1; pp = 64'(TICK_MAX); pu = 64'(TICK_MAX); end
      3: begin w = 6554; c = 7; pp = 50000; pu = 33333; end
      4: begin w = 32768; c = 0; pp = 1000; pu = 0; end
      5: begin w = 1; c = 3; pp = 0; pu = 16667; end
      default: begin
        w  = 64'($urandom_range(0, 65535));
        c  = 64'($urandom_range(1, 24));
        pp = 64'($urandom_range(1, 400000));
        pu = 64'($urandom_range(1, 250000));
      end
    endcase
    write_reg(REG_WEIGHT, w);
    write_reg(REG_PHASE_COUNT, c);
    write_reg(REG_PHASE_PERIOD, pp);
    write_reg(REG_PULSE_PERIOD, pu);
    settings_applied++;
  endtask

  // stamp driver: bursts of beats with random gaps
  always @(negedge clk) begin : stamp_driver
    stamp_cmd_t cmd;
    if (rst) begin
      stamp_ch.valid <= 1'b0;
    end else if (!stamp_ch.valid || stamp_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        stamp_ch.valid <= 1'b0;
      end else if (pending_stamps.size() > 0) begin
        cmd = pending_stamps.pop_front();
        stamp_ch.valid     <= 1'b1;
        stamp_ch.func      <= cmd.func;
        stamp_ch.timestamp <= cmd.ts;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 7);
          case ($urandom_range(0, 9))
            0, 1, 2, 3: gap_left = 0;
            4, 5, 6, 7: gap_left = $urandom_range(1, 12);
            8:          gap_left = $urandom_range(13, 80);
            default:    gap_left = $urandom_range(81, 300);
          endcase
        end
      end else begin
        stamp_ch.valid <= 1'b0;
      end
    end
  end

  // result back-pressure: short stalls, short runs, occasional long open stretches
  always @(negedge clk) begin : report_stall
    if (ready_left == 0) begin
      case ($urandom_range(0, 9))
        0: begin
          report_ch.ready <= 1'b1;
          ready_left = $urandom_range(300, 1500);
        end
        1, 2, 3: begin
          report_ch.ready <= 1'b0;
          ready_left = $urandom_range(1, 40);
        end
        default: begin
          report_ch.ready <= 1'b1;
          ready_left = $urandom_range(1, 60);
        end
      endcase
    end else begin
      ready_left--;
    end
  end

  // beat monitor: checks reports, feeds accepted stamps to the predictor
  always @(posedge clk) begin : monitor
    frame_report_t want;
    stamp_cmd_t    cmd;
    stamp_taken  = !rst && stamp_ch.valid && stamp_ch.ready;
    report_taken = !rst && report_ch.valid && report_ch.ready;
    if (report_taken) begin
      if (expected_reports.size() == 0) begin
        failures++;
        $display("%0t: report beat with none expected, frame %0d", $time,
                 report_ch.frame_number);
      end else begin
        want = expected_reports.pop_front();
        check_field("delta_ticks", 64'(want.delta), 64'(report_ch.delta_ticks));
        check_field("elapsed_ticks", 64'(want.elapsed), 64'(report_ch.elapsed_ticks));
        check_field("frame_number", 64'(want.frame), 64'(report_ch.frame_number));
        check_field("rate_average", 64'(want.rate), 64'(report_ch.rate_average));
        check_field("phase_index", 64'(want.phase), 64'(report_ch.phase_index));
        check_field("pulse_level", 64'(want.pulse), 64'(report_ch.pulse_level));
        reports_checked++;
      end
    end
    if (stamp_taken) begin
      cmd.func = stamp_ch.func;
      cmd.ts   = stamp_ch.timestamp;
      predict_stamp(cmd);
      stamps_accepted++;
    end
    if (rst || stamp_taken || report_taken) quiet_cycles = 0;
    else quiet_cycles++;
  end

  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("%0t: no beat for %0d cycles, %0d reports outstanding", $time, QUIET_LIMIT,
             expected_reports.size());
    $display("== FAIL ==");
    $finish;
  end

  initial begin : sequencer
    stamp_cmd_t cmd;
    stamp_ch.valid     = 1'b0;
    stamp_ch.func      = FUNC_STAMP;
    stamp_ch.timestamp = '0;
    report_ch.ready    = 1'b1;
    wr_en              = 1'b0;
    wr_index           = REG_WEIGHT;
    wr_data            = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed run on reset register values
    push_stamp(FUNC_STAMP, tick_t'(0));                  // origin at zero
    push_stamp(FUNC_STAMP, tick_t'(0));                  // zero interval, no average yet
    push_stamp(FUNC_STAMP, tick_t'(16667));
    push_stamp(FUNC_STAMP, tick_t'(33334));
    push_stamp(FUNC_STAMP, tick_t'(33334));              // zero interval, average held
    push_stamp(FUNC_STAMP, tick_t'(33335));              // one tick: largest rate
    push_stamp(FUNC_STAMP, TICK_MAX);                    // huge interval: rate floors
    push_stamp(FUNC_STAMP, tick_t'(5));                  // wraps past zero
    push_stamp(FUNC_RESTART, tick_t'(0));
    push_stamp(FUNC_RESTART, TICK_MAX);                  // restart while stopped
    push_stamp(FUNC_STAMP, TICK_MAX);                    // origin at top of range
    push_stamp(FUNC_STAMP, tick_t'(9));
    push_stamp(FUNC_STAMP, 48'h5555_5555_5555);
    push_stamp(FUNC_STAMP, 48'hAAAA_AAAA_AAAA);
    push_stamp(FUNC_STAMP, 48'hAAAA_AAAA_AAAA + 48'd8333);
    push_stamp(FUNC_RESTART, 48'h0);
    push_stamp(FUNC_STAMP, tick_t'(100));
    push_stamp(FUNC_STAMP, tick_t'(101));
    push_stamp(FUNC_STAMP, tick_t'(16768));
    wait_drained();

    // random runs, one per register set
    for (int k = 1; k <= SETTING_COUNT; k++) begin
      apply_setting(k);
      for (int n = 0; n < ITEMS_PER_SETTING; n++) begin
        // hold the sender mid-run until every report is back
        if (k == 3 && n == ITEMS_PER_SETTING / 2) wait_drained();
        cmd = random_stamp();
        push_stamp(cmd.func, cmd.ts);
      end
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (expected_reports.size() != 0) begin
      failures += expected_reports.size();
      $display("%0t: %0d reports never arrived", $time, expected_reports.size());
    end
    $display("Ran %0d stamps and %0d restarts over %0d register sets; %0d reports checked.",
             stamp_total, restart_total, settings_applied + 1, reports_checked);
    $display("Intervals seen: %0d zero, %0d wrapping past the top of the tick range.",
             zero_intervals, wrapped_stamps);
    if (failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
`default_nettype wire

[filelist.f]
+incdir+rtl
rtl/firm_pkg.sv
rtl/firm_ifs.sv
rtl/firm_div.sv
rtl/frame_interval_rate_meter.sv
tb/sv/testbench.sv
